FILE: sv/tfmd_pkg.sv
// Shared types and constants of the three-frame motion difference block.
// Depends on nothing; tfmd_seq, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package tfmd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned FP_W    = 20;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 20;

  // Register indexes on the configuration port.
  localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_KEEP      = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_COLOR     = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_FRAME_PIX = 2'd3;

  // Register values after reset.
  localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd20;
  localparam logic             RST_KEEP      = 1'b0;
  localparam logic             RST_COLOR     = 1'b1;
  localparam logic [FP_W-1:0]  RST_FRAME_PIX = 20'd307200;

  // Luma weights in 0.14 fixed point, with rounding.
  localparam int unsigned PROD_W  = 22;
  localparam int unsigned SUM_W   = 23;
  localparam int unsigned GRAY_SH = 14;
  localparam logic [13:0] W_RED   = 14'd4899;
  localparam logic [13:0] W_GREEN = 14'd9617;
  localparam logic [13:0] W_BLUE  = 14'd1868;
  localparam logic [SUM_W-1:0] GRAY_RND = 23'd8192;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Frame store entry: older gray in the upper byte, middle gray in the lower.
  localparam int unsigned ENTRY_W = 2 * PIX_W;

  typedef struct packed {
    logic [PIX_W-1:0] threshold;
    logic             keep;
    logic             color;
    logic [FP_W-1:0]  frame_pix;
  } tfmd_cfg_t;

  // Per-item control from the position sequencer.
  typedef struct packed {
    logic warm;  // two full frames are stored
    logic last;  // last pixel of the frame
  } tfmd_ctl_t;

endpackage

`default_nettype wire

FILE: sv/tfmd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tfmd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 524288
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tfmd_seq.sv
// Pixel position sequencer: raster position, frame end and warm-up count.
// Depends on tfmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfmd_seq
  import tfmd_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 524288
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [FP_W-1:0]               frame_pix_i,
  output logic      [$clog2(MAX_PIXELS)-1:0] pos_o,
  output tfmd_ctl_t                          ctl_o
);

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned LW = (AW + 1 > FP_W) ? AW + 1 : FP_W;

  logic [AW-1:0] pos_q, pos_d;
  logic [1:0]    frames_q, frames_d;
  logic [LW-1:0] len_raw, len_eff, pos_next;
  logic          last;

  // A length of zero acts as one, anything above the store depth as the depth.
  always_comb begin
    len_raw = LW'(frame_pix_i);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_PIXELS)) begin
      len_eff = LW'(MAX_PIXELS);
    end else begin
      len_eff = len_raw;
    end
    pos_next = LW'(pos_q) + LW'(1);
    last     = (pos_next >= len_eff);
    pos_d    = last ? '0 : pos_next[AW-1:0];
    frames_d = (last && frames_q != 2'd2) ? frames_q + 2'd1 : frames_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      frames_q <= '0;
    end else if (adv_i) begin
      pos_q    <= pos_d;
      frames_q <= frames_d;
    end
  end

  assign pos_o      = pos_q;
  assign ctl_o.warm = (frames_q == 2'd2);
  assign ctl_o.last = last;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(pos_q) < LW'(MAX_PIXELS))
    else $error("pixel position beyond the frame store");

  a_frames_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q == 2'd2 |=> frames_q == 2'd2)
    else $error("stored frame count left saturation");

endmodule

`default_nettype wire

FILE: sv/three_frame_motion_difference.sv
// Top level of the three-frame motion difference block: configuration
// registers, the two-stage read-modify-write pipeline and the output register.
// Depends on tfmd_pkg, tfmd_ram and tfmd_seq.
//
// Usage. Pixels enter in raster order on the s_axis channel, one item per
// pixel; a result item leaves on m_axis for every pixel, carrying the motion
// value and tlast on the last pixel of a frame. Configuration is written on
// the cfg port while the block is idle; writes take effect at once.
// Accepted items pass the read-stage and output registers. While the receiver
// keeps up, the block sustains one item per clock: the single frame store,
// holding both older and middle gray of a position in one entry, is read when
// an item is taken and written back as it leaves the read stage, so it sees
// one read and one write every cycle. When the frame length is one, items
// share one entry back to back and the write-back is forwarded around memory.
// Reset clears the position counter and the stored-frame count and loads the
// register defaults; the store itself is not cleared, since motion stays
// zero until two whole frames have been written. No clearing pass is run.
// When the receiver stalls, the result waits in the output register, one
// more item is held in the read stage, and only then is s_axis_tready lowered.
`timescale 1ns / 1ps
`default_nettype none

module three_frame_motion_difference
  import tfmd_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 524288
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Pixel input.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Motion output.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [7:0]         m_axis_tdata,   // motion [7:0]
  output logic                    m_axis_tlast,   // frame_end
  // Configuration writes.
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_A_W-1:0] cfg_addr_i,
  input  wire logic [CFG_D_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_PIXELS);

  // Configuration registers.
  tfmd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD: cfg_d.threshold = cfg_data_i[PIX_W-1:0];
        CFG_KEEP:      cfg_d.keep      = cfg_data_i[0];
        CFG_COLOR:     cfg_d.color     = cfg_data_i[0];
        CFG_FRAME_PIX: cfg_d.frame_pix = cfg_data_i[FP_W-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= RST_THRESHOLD;
      cfg_q.keep      <= RST_KEEP;
      cfg_q.color     <= RST_COLOR;
      cfg_q.frame_pix <= RST_FRAME_PIX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake and stage control.
  logic in_acc, s1_valid_q, s1_adv, out_valid_q;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Stage 0: position sequencing, store read and luma products.
  logic [AW-1:0] pos;
  tfmd_ctl_t     ctl;
  logic [PIX_W-1:0] in_red, in_green, in_blue;

  assign in_red   = s_axis_tdata[7:0];
  assign in_green = s_axis_tdata[15:8];
  assign in_blue  = s_axis_tdata[23:16];

  tfmd_seq #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (in_acc),
    .frame_pix_i (cfg_q.frame_pix),
    .pos_o       (pos),
    .ctl_o       (ctl)
  );

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]      s1_addr_q;

  tfmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (pos),
    .rdata_o (ram_rdata)
  );

  // A read that meets the write-back of the same entry in the same cycle
  // would return stale data, so the written entry is forwarded instead.
  logic fwd_d, fwd_q;
  assign fwd_d = ram_we && (pos == s1_addr_q);

  logic [PROD_W-1:0] s1_pr_q, s1_pg_q, s1_pb_q;
  logic [PIX_W-1:0]  s1_red_q;
  tfmd_ctl_t         s1_ctl_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      fwd_q      <= fwd_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= pos;
      s1_ctl_q  <= ctl;
      s1_red_q  <= in_red;
      s1_pr_q   <= PROD_W'(W_RED * in_red);
      s1_pg_q   <= PROD_W'(W_GREEN * in_green);
      s1_pb_q   <= PROD_W'(W_BLUE * in_blue);
    end
    if (ram_we) begin
      fwd_data_q <= ram_wdata;
    end
  end

  // Stage 1: gray value, differences, threshold and write-back.
  logic [SUM_W-1:0]   luma_sum;
  logic [SUM_W-1:0]   luma_sh;
  logic [PIX_W-1:0]   gray, older, middle, diff_a, diff_b, anded, motion_d;
  logic [ENTRY_W-1:0] entry;

  always_comb begin
    luma_sum = SUM_W'(s1_pr_q) + SUM_W'(s1_pg_q) + SUM_W'(s1_pb_q) + GRAY_RND;
    luma_sh  = luma_sum >> GRAY_SH;
    if (!cfg_q.color) begin
      gray = s1_red_q;
    end else if (luma_sh > SUM_W'(PIX_MAX)) begin
      gray = PIX_MAX;
    end else begin
      gray = luma_sh[PIX_W-1:0];
    end

    entry  = fwd_q ? fwd_data_q : ram_rdata;
    older  = entry[ENTRY_W-1:PIX_W];
    middle = entry[PIX_W-1:0];

    diff_a = (older > gray) ? older - gray : gray - older;
    diff_b = (gray > middle) ? gray - middle : middle - gray;
    anded  = diff_a & diff_b;

    if (s1_ctl_q.warm && (anded > cfg_q.threshold)) begin
      motion_d = cfg_q.keep ? anded : PIX_MAX;
    end else begin
      motion_d = '0;
    end
  end

  // The store moves on by one frame: middle becomes older, gray becomes middle.
  assign ram_we    = s1_adv;
  assign ram_wdata = {middle, gray};

  // Stage 2: output register.
  logic [PIX_W-1:0] motion_q;
  logic             last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      motion_q <= motion_d;
      last_q   <= s1_ctl_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = motion_q;
  assign m_axis_tlast  = last_q;

  // Two consecutive items share a store entry only across a frame boundary.
  a_fwd_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && fwd_d |-> s1_ctl_q.last)
    else $error("store entry reused by consecutive items inside a frame");

  // Before two whole frames are stored, no motion may be reported.
  a_warmup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_ctl_q.warm |=> m_axis_tdata == '0)
    else $error("motion reported during warm-up");

  // With both internal stages occupied and the output stalled, input must stop.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && s1_valid_q |-> !s_axis_tready)
    else $error("item accepted with the pipeline full");

endmodule

`default_nettype wire

FILE: verif/tb_three_frame_motion_difference.sv
// Self-checking testbench for three_frame_motion_difference: predicts the motion stream
// from its own copy of the two frame stores. Depends on tfmd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_three_frame_motion_difference;
  import tfmd_pkg::*;

  localparam int unsigned MAX_PIXELS     = 524288;
  // Positions below this bound are written twice before the block warms up. Once warm, no
  // frame may reach beyond them, since an entry that was never written holds no defined value.
  localparam int unsigned EXTENT         = 48;
  localparam int unsigned ITEM_TARGET    = 1550;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [PIX_W-1:0] motion;
    logic             frame_end;
  } motion_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;         // motion [7:0]
  logic               m_axis_tlast;         // frame_end
  logic               cfg_we_i   = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr_i = '0;
  logic [CFG_D_W-1:0] cfg_data_i = '0;

  three_frame_motion_difference #(
    .MAX_PIXELS(MAX_PIXELS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Pixel words waiting to be offered, and motion results still owed by the block.
  logic [23:0]    pending_pixels[$];
  motion_result_t motion_expected[$];

  // The predictor's view of the registers and of the frame stores.
  logic [PIX_W-1:0] cur_threshold = RST_THRESHOLD;
  logic             cur_keep      = RST_KEEP;
  logic             cur_color     = RST_COLOR;
  logic [FP_W-1:0]  cur_frame_pix = RST_FRAME_PIX;
  bit   [7:0]       older_gray  [MAX_PIXELS];
  bit   [7:0]       middle_gray [MAX_PIXELS];
  int unsigned      pix_pos     = 0;
  int unsigned      frames_seen = 0;

  // A static scene per position, so that a good share of the pixels shows no motion at all.
  bit [7:0] bg_red   [EXTENT];
  bit [7:0] bg_green [EXTENT];
  bit [7:0] bg_blue  [EXTENT];

  int unsigned items_sent     = 0;
  int unsigned errors         = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_armed     = 1'b0;
  logic        hold_used      = 1'b0;
  int unsigned hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gray level of one pixel: rounded luma weights in colour mode, the red sample in mono mode.
  function automatic logic [7:0] gray_of(input logic [23:0] word, input logic color);
    int unsigned sum;
    if (!color) return word[7:0];
    sum = (4899 * word[7:0] + 9617 * word[15:8] + 1868 * word[23:16] + 8192) >> 14;
    return (sum > 255) ? 8'd255 : sum[7:0];
  endfunction

  // Works out the result of one accepted pixel and moves both stores on by that pixel.
  task automatic predict_motion(input logic [23:0] word);
    int unsigned    span;
    logic [7:0]     older_diff;
    logic [7:0]     middle_diff;
    logic [7:0]     anded;
    logic [7:0]     gray;
    logic [7:0]     old_g;
    logic [7:0]     mid_g;
    motion_result_t res;
    span  = (cur_frame_pix == 0) ? 1 : ((cur_frame_pix > MAX_PIXELS) ? MAX_PIXELS : cur_frame_pix);
    gray  = gray_of(word, cur_color);
    old_g = older_gray[pix_pos];
    mid_g = middle_gray[pix_pos];
    res.motion = '0;
    // Until two whole frames are stored there is nothing to compare against.
    if (frames_seen >= 2) begin
      older_diff  = (old_g > gray) ? old_g - gray : gray - old_g;
      middle_diff = (gray > mid_g) ? gray - mid_g : mid_g - gray;
      anded = older_diff & middle_diff;
      if (anded > cur_threshold) res.motion = cur_keep ? anded : PIX_MAX;
    end
    older_gray[pix_pos]  = mid_g;
    middle_gray[pix_pos] = gray;
    // A frame also ends at once when a shorter length leaves the position already past its end.
    res.frame_end = (pix_pos + 1 >= span);
    if (res.frame_end) begin
      pix_pos = 0;
      if (frames_seen < 2) frames_seen++;
    end else begin
      pix_pos++;
    end
    motion_expected.insert(motion_expected.size(), res);
  endtask

  // Sender: a word stays on the bus until it is taken; a new one is offered unless the sender
  // chooses to idle this cycle.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block fill and back-pressure
  // its input while items keep being offered.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_left     <= LONG_HOLD;
      hold_used     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checker and watchdog. The outgoing item is checked before the incoming one is predicted,
  // so both ends share one queue without racing.
  always @(posedge clk_i) begin
    motion_result_t want;
    logic           progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1'b1;
        if (motion_expected.size() == 0) begin
          $display("%t: unexpected result item, motion %0d frame_end %0d",
                   $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = motion_expected.pop_front();
          if (m_axis_tdata !== want.motion || m_axis_tlast !== want.frame_end) begin
            $display("%t: mismatch, expected motion %0d frame_end %0d, got motion %0d frame_end %0d",
                     $time, want.motion, want.frame_end, m_axis_tdata, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        progress = 1'b1;
        predict_motion(s_axis_tdata);
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%t: no item has moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL three_frame_motion_difference");
        $finish;
      end
    end
  end

  // Register write; the predictor takes the value the block will hold after the same edge.
  task automatic write_register(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_THRESHOLD: cur_threshold = value[PIX_W-1:0];
      CFG_KEEP:      cur_keep      = value[0];
      CFG_COLOR:     cur_color     = value[0];
      CFG_FRAME_PIX: cur_frame_pix = value[FP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pending_pixels.insert(pending_pixels.size(), {b, g, r});
    items_sent++;
  endtask

  // Mostly the static scene, sometimes a little noise on it, sometimes something new or extreme.
  task automatic queue_scene_pixel(input int unsigned slot);
    int unsigned k;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      bg_red[slot]   = 8'($urandom_range(0, 255));
      bg_green[slot] = 8'($urandom_range(0, 255));
      bg_blue[slot]  = 8'($urandom_range(0, 255));
    end
    r = bg_red[slot];
    g = bg_green[slot];
    b = bg_blue[slot];
    if (k >= 35 && k < 55) begin
      r ^= 8'($urandom_range(0, 3));
      g ^= 8'($urandom_range(0, 3));
      b ^= 8'($urandom_range(0, 3));
    end else if (k >= 55 && k < 80) begin
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
    end else if (k >= 80 && k < 90) begin
      r = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
      g = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
      b = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
    end
    queue_pixel(r, g, b);
  endtask

  // Waits until every pixel has been taken and every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_pixels.size() != 0 || s_axis_tvalid || motion_expected.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned span;
    int unsigned slot;
    logic        wide;
    logic [FP_W-1:0] len;
    logic [7:0]  thr;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Extremes of every channel under the reset settings. The frame is still far from full,
    // so these only seed the stores and must give no motion.
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    wait_drained();

    // Cut the frame to EXTENT pixels mid-stream and fill two whole frames: warm-up, motion zero.
    write_register(CFG_FRAME_PIX, CFG_D_W'(EXTENT));
    for (int unsigned i = 5; i < 2 * EXTENT; i++) queue_scene_pixel(i % EXTENT);
    wait_drained();

    // A length of zero acts as one: back-to-back items all hit the same store entry.
    write_register(CFG_FRAME_PIX, '0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd128, 8'd128, 8'd128);
    wait_drained();

    // Lowest threshold with the difference kept as it is.
    write_register(CFG_THRESHOLD, '0);
    write_register(CFG_KEEP, CFG_D_W'(1));
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd1, 8'd1, 8'd1);
    queue_pixel(8'd0, 8'd0, 8'd0);
    wait_drained();

    // Mono mode, where only red counts, with the highest threshold that nothing can pass.
    write_register(CFG_COLOR, '0);
    write_register(CFG_THRESHOLD, CFG_D_W'(PIX_MAX));
    write_register(CFG_FRAME_PIX, CFG_D_W'(1));
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd17, 8'd99);
    queue_pixel(8'd0, 8'd0, 8'd0);
    wait_drained();

    // A length beyond the store size acts as the store size; a few pixels into that frame the
    // length drops below the position, and the next pixel ends the frame.
    write_register(CFG_THRESHOLD, CFG_D_W'(100));
    write_register(CFG_KEEP, '0);
    write_register(CFG_COLOR, CFG_D_W'(1));
    write_register(CFG_FRAME_PIX, 20'hFFFFF);
    for (int unsigned i = 0; i < 6; i++) queue_scene_pixel(i);
    wait_drained();
    write_register(CFG_FRAME_PIX, CFG_D_W'(3));
    for (int unsigned i = 0; i < 4; i++) queue_scene_pixel(i);
    wait_drained();

    // Random phases, cycling through the idling patterns, each with fresh register values.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 66; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 66; end
        default: begin send_idle_pct <= 30; recv_stall_pct <= 30; end
      endcase
      case ($urandom_range(0, 7))
        0:       thr = '0;
        1:       thr = PIX_MAX;
        2, 3, 4: thr = 8'($urandom_range(0, 40));
        default: thr = 8'($urandom_range(0, 255));
      endcase
      write_register(CFG_THRESHOLD, CFG_D_W'(thr));
      write_register(CFG_KEEP, CFG_D_W'($urandom_range(0, 1)));
      write_register(CFG_COLOR, CFG_D_W'($urandom_range(0, 1)));
      // A long frame gets only as many pixels as stay within the twice-written positions, and
      // leaves the next position inside them too.
      wide = (phase != 0) && (pix_pos < EXTENT - 1) && ($urandom_range(0, 99) < 15);
      if (wide) begin
        case ($urandom_range(0, 3))
          0:       len = 20'hFFFFF;
          1:       len = FP_W'(MAX_PIXELS);
          2:       len = FP_W'(MAX_PIXELS + 1);
          default: len = FP_W'($urandom_range(EXTENT + 1, 20'hFFFFF));
        endcase
        n = $urandom_range(1, EXTENT - 1 - pix_pos);
      end else begin
        case ($urandom_range(0, 5))
          0:       len = '0;
          1:       len = 20'd1;
          2:       len = 20'd2;
          3:       len = FP_W'(EXTENT);
          default: len = FP_W'($urandom_range(3, EXTENT));
        endcase
        n = (phase == 0) ? 150 : $urandom_range(20, 100);
      end
      write_register(CFG_FRAME_PIX, len);
      span = (len == 0) ? 1 : ((len > EXTENT) ? EXTENT : len);
      slot = pix_pos % span;
      for (int unsigned i = 0; i < n; i++) begin
        queue_scene_pixel(slot);
        slot = (slot + 1) % span;
      end
      if (phase == 0) hold_armed <= 1'b1;
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS three_frame_motion_difference");
    end else begin
      $display("FAIL three_frame_motion_difference");
    end
    $finish;
  end

endmodule
